>>> rtl/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// shared constants and register map of the cubic bezier point evaluator
// ----------------------------------------------------------------------------
package cbpe_pkg;

    localparam int unsigned COORD_W  = 16;
    localparam int unsigned T_W      = 17;
    localparam int unsigned CHORD_W  = 17;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;

    // 1.0 in unsigned q1.16
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // octagonal chord estimate coefficients, q0.16
    localparam logic [15:0] CHORD_MIN_COEF = 16'd26870;
    localparam logic [15:0] CHORD_MAX_COEF = 16'd61685;
    localparam logic [CHORD_W-1:0] CHORD_LIMIT = 17'h1ffff;

    typedef enum logic [2:0] {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } reg_idx_t;

endpackage

>>> rtl/cubic_bezier_point_eval_unit.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_unit
// 2d cubic bezier point evaluator with octagonal chord-length estimate
// ----------------------------------------------------------------------------
// The unit takes one curve parameter t per clock and returns the curve point
// and the p0-to-p3 chord estimate with one result per clock while out_stall
// is low. The de Casteljau pipeline has five register stages: t clamp, one
// stage for each of the first two interpolation levels, one for the split
// partial products of the last level and one for the final sum, rounding and
// saturation. A result moves through these stages in order, and out_stall
// holds the pipeline back. The control points are written over the apb port
// and must only change while no item is in flight.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_unit
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbpe_pkg::ADDR_W-1:0]        paddr,
    input  logic [cbpe_pkg::DATA_W-1:0]        pwdata,
    output logic [cbpe_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cbpe_pkg::T_W-1:0]           t,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [cbpe_pkg::COORD_W-1:0] point_x,
    output logic signed [cbpe_pkg::COORD_W-1:0] point_y,
    output logic [cbpe_pkg::CHORD_W-1:0]       chord_length
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] cp_reg [cbpe_pkg::NUM_REGS];
    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic [15:0]        rd_val;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];
    assign rd_val  = cp_reg[cfg_idx];
    assign prdata  = {{16{rd_val[15]}}, rd_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cbpe_pkg::NUM_REGS; i++)
            begin
                cp_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            cp_reg[cfg_idx] <= pwdata[15:0];
        end
    end

    // control points per axis, axis 0 is x
    logic signed [15:0] pt [2][4];

    assign pt[0][0] = cp_reg[cbpe_pkg::REG_P0_X];
    assign pt[0][1] = cp_reg[cbpe_pkg::REG_P1_X];
    assign pt[0][2] = cp_reg[cbpe_pkg::REG_P2_X];
    assign pt[0][3] = cp_reg[cbpe_pkg::REG_P3_X];
    assign pt[1][0] = cp_reg[cbpe_pkg::REG_P0_Y];
    assign pt[1][1] = cp_reg[cbpe_pkg::REG_P1_Y];
    assign pt[1][2] = cp_reg[cbpe_pkg::REG_P2_Y];
    assign pt[1][3] = cp_reg[cbpe_pkg::REG_P3_Y];

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5;

    assign en5      = !out_valid_reg || !out_stall;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg        <= in_valid;
            if (en2) v2_reg        <= v1_reg;
            if (en3) v3_reg        <= v2_reg;
            if (en4) v4_reg        <= v3_reg;
            if (en5) out_valid_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: clamp t
    // ------------------------------------------------------------------
    logic [16:0] t1_reg, t1_next;

    assign t1_next = (t > cbpe_pkg::T_ONE) ? cbpe_pkg::T_ONE : t;

    always_ff @(posedge clk)
    begin
        if (en1) t1_reg <= t1_next;
    end

    // ------------------------------------------------------------------
    // stage 2: first interpolation level, q = p_i + t*(p_i+1 - p_i)
    // ------------------------------------------------------------------
    logic signed [17:0] ts1;
    logic signed [16:0] d1   [2][3];
    logic signed [34:0] m1   [2][3];
    logic signed [34:0] s1   [2][3];
    logic signed [31:0] q2_reg  [2][3];
    logic signed [31:0] q2_next [2][3];
    logic [16:0]        t2_reg;
    logic signed [16:0] cdx, cdy;
    logic [15:0]        dx2_reg, dy2_reg, dx2_next, dy2_next;

    assign ts1 = $signed({1'b0, t1_reg});

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1[a][i] = {pt[a][i+1][15], pt[a][i+1]} - {pt[a][i][15], pt[a][i]};
                m1[a][i] = ts1 * d1[a][i];
                s1[a][i] = $signed({{3{pt[a][i][15]}}, pt[a][i], 16'h0000}) + m1[a][i];
                q2_next[a][i] = s1[a][i][31:0];
            end
        end
    end

    // endpoint differences for the chord estimate
    assign cdx      = {pt[0][3][15], pt[0][3]} - {pt[0][0][15], pt[0][0]};
    assign cdy      = {pt[1][3][15], pt[1][3]} - {pt[1][0][15], pt[1][0]};
    assign dx2_next = cdx[16] ? 16'(-cdx) : cdx[15:0];
    assign dy2_next = cdy[16] ? 16'(-cdy) : cdy[15:0];

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            t2_reg  <= t1_reg;
            q2_reg  <= q2_next;
            dx2_reg <= dx2_next;
            dy2_reg <= dy2_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: second interpolation level
    // ------------------------------------------------------------------
    logic signed [17:0] ts2;
    logic signed [32:0] d2   [2][2];
    logic signed [50:0] m2   [2][2];
    logic signed [50:0] s2   [2][2];
    logic signed [47:0] r3_reg  [2][2];
    logic signed [47:0] r3_next [2][2];
    logic [16:0]        t3_reg;
    logic [15:0]        mn3_reg, mx3_reg, mn3_next, mx3_next;

    assign ts2 = $signed({1'b0, t2_reg});

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                d2[a][i] = {q2_reg[a][i+1][31], q2_reg[a][i+1]}
                         - {q2_reg[a][i][31], q2_reg[a][i]};
                m2[a][i] = ts2 * d2[a][i];
                s2[a][i] = $signed({{3{q2_reg[a][i][31]}}, q2_reg[a][i], 16'h0000})
                         + m2[a][i];
                r3_next[a][i] = s2[a][i][47:0];
            end
        end
    end

    assign mn3_next = (dx2_reg < dy2_reg) ? dx2_reg : dy2_reg;
    assign mx3_next = (dx2_reg < dy2_reg) ? dy2_reg : dx2_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            t3_reg  <= t2_reg;
            r3_reg  <= r3_next;
            mn3_reg <= mn3_next;
            mx3_reg <= mx3_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: last level, t*(r1 - r0) split into two partial products
    // ------------------------------------------------------------------
    logic signed [17:0] ts3;
    logic signed [48:0] d3        [2];
    logic signed [24:0] d3_hi     [2];
    logic signed [42:0] phi4_next [2];
    logic [40:0]        plo4_next [2];
    logic signed [42:0] phi4_reg  [2];
    logic [40:0]        plo4_reg  [2];
    logic signed [47:0] base4_reg [2];
    logic [31:0]        cmn4_reg, cmx4_reg, cmn4_next, cmx4_next;

    assign ts3 = $signed({1'b0, t3_reg});

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            d3[a]        = {r3_reg[a][1][47], r3_reg[a][1]} - {r3_reg[a][0][47], r3_reg[a][0]};
            d3_hi[a]     = d3[a][48:24];
            phi4_next[a] = ts3 * d3_hi[a];
            plo4_next[a] = {24'h000000, t3_reg} * {17'h00000, d3[a][23:0]};
        end
    end

    assign cmn4_next = {16'h0000, mn3_reg} * {16'h0000, cbpe_pkg::CHORD_MIN_COEF};
    assign cmx4_next = {16'h0000, mx3_reg} * {16'h0000, cbpe_pkg::CHORD_MAX_COEF};

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            for (int a = 0; a < 2; a++)
            begin
                phi4_reg[a]  <= phi4_next[a];
                plo4_reg[a]  <= plo4_next[a];
                base4_reg[a] <= r3_reg[a][0];
            end
            cmn4_reg <= cmn4_next;
            cmx4_reg <= cmx4_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: final sum, round half up, saturate
    // ------------------------------------------------------------------
    localparam logic signed [67:0] RND_HALF = 68'sh0_0000_8000_0000_0000;
    localparam logic signed [19:0] SAT_HI   = 20'sd32767;
    localparam logic signed [19:0] SAT_LO   = -20'sd32768;

    logic signed [67:0] acc5 [2];
    logic signed [19:0] rnd5 [2];
    logic signed [15:0] pt5  [2];
    logic [33:0]        csum5;
    logic [17:0]        cshift5;
    logic [16:0]        chord5;
    logic signed [15:0] point_x_reg, point_y_reg;
    logic [16:0]        chord_length_reg;

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            acc5[a] = $signed({{4{base4_reg[a][47]}}, base4_reg[a], 16'h0000})
                    + $signed({phi4_reg[a][42], phi4_reg[a], 24'h000000})
                    + $signed({27'h0000000, plo4_reg[a]})
                    + RND_HALF;
            rnd5[a] = acc5[a][67:48];
            if (rnd5[a] > SAT_HI)
            begin
                pt5[a] = SAT_HI[15:0];
            end
            else if (rnd5[a] < SAT_LO)
            begin
                pt5[a] = SAT_LO[15:0];
            end
            else
            begin
                pt5[a] = rnd5[a][15:0];
            end
        end
    end

    assign csum5   = {2'b00, cmn4_reg} + {2'b00, cmx4_reg} + 34'h000008000;
    assign cshift5 = csum5[33:16];
    assign chord5  = (cshift5 > {1'b0, cbpe_pkg::CHORD_LIMIT}) ? cbpe_pkg::CHORD_LIMIT
                                                               : cshift5[16:0];

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            point_x_reg      <= pt5[0];
            point_y_reg      <= pt5[1];
            chord_length_reg <= chord5;
        end
    end

    assign point_x      = point_x_reg;
    assign point_y      = point_y_reg;
    assign chord_length = chord_length_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the input side only stalls when the first stage holds an item
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg
    ) else $error("input stalled with empty first stage");

    // an input transfer lands in the first stage
    a_accept_lands: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg
    ) else $error("accepted item lost at stage 1");

    // an item leaving the last internal stage shows up at the output
    a_last_stage_moves: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v4_reg && en5) |=> out_valid
    ) else $error("item lost between stage 4 and output");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the cubic bezier point evaluator
// ----------------------------------------------------------------------------
// Loads control points over the apb port while the pipeline is empty, streams
// curve parameters through the valid/stall input and compares every output
// transfer with a bit-exact integer model of the curve sum and the chord
// estimate. A short directed table covers reset values, extreme control
// points, t at and beyond 1.0, the saturation guard and half rounding; random
// phases with fresh control points follow, random stalls and non-burst gaps.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned PIPE_LAT    = 5;
    localparam longint      T_UNIT      = 65536;
    localparam longint      MIN_WEIGHT  = 26870;
    localparam longint      MAX_WEIGHT  = 61685;
    localparam longint      LEN_CEILING = 131071;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_ITEMS = 144;

    typedef struct packed {
        logic signed [cbpe_pkg::COORD_W-1:0] x;
        logic signed [cbpe_pkg::COORD_W-1:0] y;
        logic [cbpe_pkg::CHORD_W-1:0]        len;
    } curve_result_t;

    typedef struct packed {
        logic [cbpe_pkg::T_W-1:0] tv;
        curve_result_t            res;
    } pending_point_t;

    typedef struct {
        bit                       is_write;
        cbpe_pkg::reg_idx_t       idx;
        logic [15:0]              val;
        logic [cbpe_pkg::T_W-1:0] tv;
        bit                       typed;
        curve_result_t            res;
    } dir_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [cbpe_pkg::ADDR_W-1:0]         paddr;
    logic [cbpe_pkg::DATA_W-1:0]         pwdata;
    logic [cbpe_pkg::DATA_W-1:0]         prdata;
    logic                                pready;
    logic                                in_valid;
    logic                                in_stall;
    logic [cbpe_pkg::T_W-1:0]            t;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [cbpe_pkg::COORD_W-1:0] point_x;
    logic signed [cbpe_pkg::COORD_W-1:0] point_y;
    logic [cbpe_pkg::CHORD_W-1:0]        chord_length;

    logic signed [cbpe_pkg::COORD_W-1:0] ctrl_pts [cbpe_pkg::NUM_REGS];
    pending_point_t                      pending_points [$];
    dir_row_t                            dir_rows [$];
    int unsigned                         err_count;

    cubic_bezier_point_eval_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .t            (t),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .chord_length (chord_length)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // curve model
    // ------------------------------------------------------------------------
    function automatic logic signed [cbpe_pkg::COORD_W-1:0] blend_coord(
        input logic signed [71:0] w0, input logic signed [71:0] w1,
        input logic signed [71:0] w2, input logic signed [71:0] w3,
        input logic signed [cbpe_pkg::COORD_W-1:0] a,
        input logic signed [cbpe_pkg::COORD_W-1:0] b,
        input logic signed [cbpe_pkg::COORD_W-1:0] c,
        input logic signed [cbpe_pkg::COORD_W-1:0] d);
        logic signed [71:0] acc;
        logic signed [71:0] r;
        acc = w0 * a + w1 * b + w2 * c + w3 * d;
        // q16.48 -> q16.0, halves go toward +inf
        r = (acc + (72'sd1 <<< 47)) >>> 48;
        if (r > 72'sd32767)
            r = 72'sd32767;
        if (r < -72'sd32768)
            r = -72'sd32768;
        return r[cbpe_pkg::COORD_W-1:0];
    endfunction

    function automatic curve_result_t eval_curve_point(input logic [cbpe_pkg::T_W-1:0] tv);
        longint unsigned tc;
        longint unsigned u;
        logic signed [71:0] w0, w1, w2, w3;
        longint dx, dy, mn, mx, len;
        curve_result_t res;
        tc = (tv > T_UNIT) ? T_UNIT : tv;
        u  = T_UNIT - tc;
        w0 = 72'(u * u * u);
        w1 = 72'(3 * u * u * tc);
        w2 = 72'(3 * u * tc * tc);
        w3 = 72'(tc * tc * tc);
        res.x = blend_coord(w0, w1, w2, w3,
                            ctrl_pts[cbpe_pkg::REG_P0_X], ctrl_pts[cbpe_pkg::REG_P1_X],
                            ctrl_pts[cbpe_pkg::REG_P2_X], ctrl_pts[cbpe_pkg::REG_P3_X]);
        res.y = blend_coord(w0, w1, w2, w3,
                            ctrl_pts[cbpe_pkg::REG_P0_Y], ctrl_pts[cbpe_pkg::REG_P1_Y],
                            ctrl_pts[cbpe_pkg::REG_P2_Y], ctrl_pts[cbpe_pkg::REG_P3_Y]);
        dx = longint'(ctrl_pts[cbpe_pkg::REG_P3_X]) - longint'(ctrl_pts[cbpe_pkg::REG_P0_X]);
        dy = longint'(ctrl_pts[cbpe_pkg::REG_P3_Y]) - longint'(ctrl_pts[cbpe_pkg::REG_P0_Y]);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        mn  = (dx < dy) ? dx : dy;
        mx  = (dx < dy) ? dy : dx;
        len = (mn * MIN_WEIGHT + mx * MAX_WEIGHT + 32768) >>> 16;
        if (len > LEN_CEILING)
            len = LEN_CEILING;
        res.len = len[cbpe_pkg::CHORD_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] rand_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return 16'h8000;
        else if (r < 24)
            return 16'h7fff;
        else if (r < 30)
            return 16'h0000;
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [cbpe_pkg::T_W-1:0] rand_t();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 17'($urandom_range(0, 65536));
        else if (r < 80)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return 17'd1;
                2:       return 17'd65535;
                default: return cbpe_pkg::T_ONE;
            endcase
        end
        else if (r < 90)
            return 17'($urandom_range(65537, 131071));
        else
            return 17'($urandom_range(0, 131071));
    endfunction

    function automatic void add_write(input cbpe_pkg::reg_idx_t idx, input logic [15:0] val);
        dir_row_t row;
        row.is_write = 1'b1;
        row.idx      = idx;
        row.val      = val;
        row.tv       = '0;
        row.typed    = 1'b0;
        row.res      = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_item(input logic [cbpe_pkg::T_W-1:0] tv, input bit typed,
                                     input int x, input int y, input int len);
        dir_row_t row;
        row.is_write = 1'b0;
        row.idx      = cbpe_pkg::REG_P0_X;
        row.val      = '0;
        row.tv       = tv;
        row.typed    = typed;
        row.res.x    = x[cbpe_pkg::COORD_W-1:0];
        row.res.y    = y[cbpe_pkg::COORD_W-1:0];
        row.res.len  = len[cbpe_pkg::CHORD_W-1:0];
        dir_rows.push_back(row);
    endfunction

    function automatic void add_point_set(input logic [15:0] x0, input logic [15:0] y0,
                                          input logic [15:0] x1, input logic [15:0] y1,
                                          input logic [15:0] x2, input logic [15:0] y2,
                                          input logic [15:0] x3, input logic [15:0] y3);
        add_write(cbpe_pkg::REG_P0_X, x0);
        add_write(cbpe_pkg::REG_P0_Y, y0);
        add_write(cbpe_pkg::REG_P1_X, x1);
        add_write(cbpe_pkg::REG_P1_Y, y1);
        add_write(cbpe_pkg::REG_P2_X, x2);
        add_write(cbpe_pkg::REG_P2_Y, y2);
        add_write(cbpe_pkg::REG_P3_X, x3);
        add_write(cbpe_pkg::REG_P3_Y, y3);
    endfunction

    task automatic apb_write(input cbpe_pkg::reg_idx_t idx, input logic [15:0] val);
        logic [15:0] upper;
        upper = 16'($urandom_range(0, 65535));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {upper, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ctrl_pts[idx] = val;
        // idle the bus before the next write
        @(posedge clk);
    endtask

    // returns in the time step of the transfer
    task automatic send_t(input logic [cbpe_pkg::T_W-1:0] tv, input int unsigned gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        t        <= tv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 3) @(posedge clk);
    endtask

    task automatic report_mismatch(input string fld, input logic [cbpe_pkg::T_W-1:0] tv,
                                   input int exp_v, input int got_v);
        $display("mismatch %s at t=%0d: expected %0d, got %0d", fld, tv, exp_v, got_v);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // output side: stall pattern and result checking
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        int unsigned run;
        int unsigned hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r    = $urandom_range(0, 99);
            run  = (r < 12) ? $urandom_range(40, 200) : $urandom_range(1, 6);
            r    = $urandom_range(0, 99);
            hold = (r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            repeat (run) @(posedge clk);
            out_stall <= 1'b1;
            repeat (hold) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        pending_point_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_points.size() == 0)
            begin
                report_mismatch("unexpected transfer", '0, 0, int'(point_x));
            end
            else
            begin
                e = pending_points.pop_front();
                if (point_x !== e.res.x)
                    report_mismatch("point_x", e.tv, int'(e.res.x), int'(point_x));
                if (point_y !== e.res.y)
                    report_mismatch("point_y", e.tv, int'(e.res.y), int'(point_y));
                if (chord_length !== e.res.len)
                    report_mismatch("chord_length", e.tv, int'(e.res.len),
                                    int'(chord_length));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        pending_point_t p;
        int unsigned    pause_at;
        int unsigned    guard;
        bit             burst;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        t         = '0;
        err_count = 0;
        for (int i = 0; i < cbpe_pkg::NUM_REGS; i++)
            ctrl_pts[i] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: every point is the origin
        add_item(17'd0,           1'b1, 0, 0, 0);
        add_item(cbpe_pkg::T_ONE, 1'b1, 0, 0, 0);
        add_item(17'h1ffff,       1'b1, 0, 0, 0);
        // opposite corners: t=0 gives p0, t at or past one gives p3
        add_point_set(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                      16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        add_item(17'd0,           1'b1, -32768,  32767, 88554);
        add_item(cbpe_pkg::T_ONE, 1'b1,  32767, -32768, 88554);
        add_item(17'd65537,       1'b1,  32767, -32768, 88554);
        add_item(17'h1ffff,       1'b1,  32767, -32768, 88554);
        add_item(17'd1,           1'b0, 0, 0, 0);
        add_item(17'd65535,       1'b0, 0, 0, 0);
        add_item(17'd32768,       1'b0, 0, 0, 0);
        add_item(17'd21845,       1'b0, 0, 0, 0);
        add_item(17'd43691,       1'b0, 0, 0, 0);
        // all points on the range edge: the saturation guard must not bite
        add_point_set(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                      16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_item(17'd32768,       1'b1, 32767, 32767, 0);
        add_item(17'd12345,       1'b1, 32767, 32767, 0);
        add_point_set(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_item(17'd40000,       1'b1, -32768, -32768, 0);
        // exact halves round toward +inf on both signs
        add_point_set(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 16'h0004, 16'hfffc);
        add_item(17'd32768,       1'b1, 1, 0, 5);
        add_item(17'd16384,       1'b0, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_write)
            begin
                drain_pipeline();
                apb_write(dir_rows[i].idx, dir_rows[i].val);
            end
            else
            begin
                send_t(dir_rows[i].tv, pick_gap());
                p.tv  = dir_rows[i].tv;
                p.res = dir_rows[i].typed ? dir_rows[i].res
                                          : eval_curve_point(dir_rows[i].tv);
                pending_points.push_back(p);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_pipeline();
            for (int i = 0; i < cbpe_pkg::NUM_REGS; i++)
                apb_write(cbpe_pkg::reg_idx_t'(i), rand_coord());
            burst    = (ph % 3 == 1);
            pause_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off until the pipeline has emptied once per phase
                if (n == pause_at)
                    drain_pipeline();
                p.tv = rand_t();
                send_t(p.tv, burst ? 0 : pick_gap());
                p.res = eval_curve_point(p.tv);
                pending_points.push_back(p);
            end
        end

        in_valid <= 1'b0;
        guard = 0;
        while (pending_points.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_LAT + 5) @(posedge clk);
        if (pending_points.size() != 0)
            report_mismatch("missing transfers", pending_points[0].tv,
                            0, int'(pending_points.size()));

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
